[rtl/core/dccps_pkg.sv]
// ----------------------------------------------------------------------------
// dccps_pkg
// Shared types, constants and helpers of the DCC packet serializer.
// ----------------------------------------------------------------------------
package dccps_pkg;

	// Pending packet queue
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// Frame layout
	localparam logic [6:0] PREAMBLE_ONES = 7'd22;
	localparam logic [6:0] FRAME_LEN_2   = 7'd49;
	localparam logic [6:0] FRAME_LEN_3   = 7'd58;
	localparam logic [6:0] FRAME_LEN_4   = 7'd67;
	localparam logic [6:0] FRAME_LEN_5   = 7'd76;
	localparam logic [3:0] LAST_POS      = 4'd8;
	localparam logic [2:0] MIN_LEN       = 3'd2;
	localparam logic [2:0] MAX_LEN       = 3'd5;

	// Idle packet register reset values
	localparam logic [7:0] IDLE_FIRST_RST  = 8'hFF;
	localparam logic [7:0] IDLE_SECOND_RST = 8'h00;

	// Configuration register indexes
	localparam logic REG_IDLE_FIRST  = 1'b0;
	localparam logic REG_IDLE_SECOND = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_BIT  = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Input transaction, laid out as on tdata (payload in the low bits)
	typedef struct packed {
		logic        drain_first;
		logic [7:0]  repeat_count;
		logic [2:0]  payload_length;
		logic [39:0] payload;
	} load_req_t;

	// One queued packet
	typedef struct packed {
		logic [7:0]  repeats;
		logic [2:0]  length;
		logic [39:0] payload;
	} entry_t;

	// Frame length in bits for a legal payload length
	function automatic logic [6:0] frame_bits(input logic [2:0] len);
		logic [6:0] n;
		n = FRAME_LEN_2;
		unique case (len)
			3'd3:    n = FRAME_LEN_3;
			3'd4:    n = FRAME_LEN_4;
			3'd5:    n = FRAME_LEN_5;
			default: n = FRAME_LEN_2;
		endcase
		return n;
	endfunction

endpackage

[rtl/core/dcc_packet_serializer.sv]
// ----------------------------------------------------------------------------
// dcc_packet_serializer
// Queues DCC packets and emits their frames one line bit per bit request.
// ----------------------------------------------------------------------------
// The input transaction is captured on acceptance; in the execute state the
//   result register is loaded once it is free, and m_axis_tvalid then rises.
// A new transaction is taken only in the idle state, after the last one has
//   executed; execute waits while a previous result is held on m_axis.
// Frames go out bit-serially from an octet shift register; checksum builds up
//   one octet at a time.
// Reset clears queue pointers and current packet, presets the idle registers;
//   the pending store is not cleared and needs no clearing pass.
module dcc_packet_serializer
	import dccps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] payload_0, [15:8] payload_1, [23:16] payload_2, [31:24] payload_3,
	// [39:32] payload_4, [42:40] payload_length, [50:43] repeat_count,
	// [51] drain_first, [55:52] zero
	input  logic [55:0] s_axis_tdata,
	// [1:0] command
	input  logic [1:0]  s_axis_tuser,
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] bit_out, [1] load_accepted, [6:2] pending_count, [7] zero
	output logic [7:0]  m_axis_tdata,
	// [0] sending_idle
	output logic        m_axis_tuser,
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// Control
	state_t state_q, state_d;
	logic   work_go;

	// Captured transaction
	load_req_t req_q;
	logic [1:0] cmd_q;

	// Idle packet registers
	logic [7:0] idle_first_q, idle_second_q;

	// Queue
	entry_t            mem [QUEUE_DEPTH];
	entry_t            rd_q;
	logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d, wr_addr;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              push;
	entry_t            wr_entry;

	// Current packet
	logic [39:0] act_payload_q, act_payload_d;
	logic [2:0]  act_len_q, act_len_d;
	logic [6:0]  act_idx_q, act_idx_d;
	logic [7:0]  act_rep_q, act_rep_d;
	logic        act_valid_q, act_valid_d;
	logic        act_idle_q, act_idle_d;

	// Serial frame datapath
	logic [39:0] work_q, work_d;
	logic [7:0]  octet_q, octet_d;
	logic [7:0]  csum_q, csum_d;
	logic [3:0]  pos_q, pos_d;
	logic [2:0]  byte_q, byte_d;

	// Result register
	logic       out_valid_q;
	logic [7:0] out_data_q, out_data_d;
	logic       out_user_q, out_user_d;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Execute once the result register is free
	assign work_go = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (work_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Transaction capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q <= load_req_t'(s_axis_tdata[51:0]);
			cmd_q <= s_axis_tuser;
		end
	end

	// Idle packet registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_first_q  <= IDLE_FIRST_RST;
			idle_second_q <= IDLE_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IDLE_FIRST:  idle_first_q  <= cfg_data;
				REG_IDLE_SECOND: idle_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pending store: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (push) mem[wr_addr] <= wr_entry;
		rd_q <= mem[head_q];
	end

	assign wr_entry = '{repeats: req_q.repeat_count, length: req_q.payload_length,
		payload: req_q.payload};

	// Command execution
	always_comb begin
		logic        start;
		logic        still_valid;
		logic        bit_v;
		logic        acc_v;
		logic [6:0]  e_idx;
		logic [39:0] e_work;
		logic [7:0]  e_octet, e_csum;
		logic [3:0]  e_pos;
		logic [2:0]  e_byte, len_v;

		head_d        = head_q;
		tail_d        = tail_q;
		fill_d        = fill_q;
		push          = 1'b0;
		wr_addr       = tail_q;
		act_payload_d = act_payload_q;
		act_len_d     = act_len_q;
		act_idx_d     = act_idx_q;
		act_rep_d     = act_rep_q;
		act_valid_d   = act_valid_q;
		act_idle_d    = act_idle_q;
		work_d        = work_q;
		octet_d       = octet_q;
		csum_d        = csum_q;
		pos_d         = pos_q;
		byte_d        = byte_q;
		start         = 1'b0;
		still_valid   = act_valid_q;
		bit_v         = 1'b0;
		acc_v         = 1'b0;
		len_v         = req_q.payload_length;
		out_user_d    = 1'b0;
		e_idx         = act_idx_q;
		e_work        = work_q;
		e_octet       = octet_q;
		e_csum        = csum_q;
		e_pos         = pos_q;
		e_byte        = byte_q;

		if (work_go) begin
			case (cmd_q)
				CMD_LOAD: begin
					// Optional drain, then push if legal and room
					if (req_q.drain_first) begin
						head_d = '0;
						tail_d = '0;
						fill_d = '0;
					end
					if (len_v >= MIN_LEN && len_v <= MAX_LEN
					    && fill_d != FILL_W'(QUEUE_DEPTH)) begin
						push    = 1'b1;
						wr_addr = tail_d;
						tail_d  = (tail_d == PTR_W'(QUEUE_DEPTH - 1)) ? '0
						          : tail_d + PTR_W'(1);
						fill_d  = fill_d + FILL_W'(1);
						acc_v   = 1'b1;
					end
				end
				CMD_BIT: begin
					// End of frame: repeat or retire
					if (act_valid_q && act_idx_q >= frame_bits(act_len_q)) begin
						if (act_rep_q != 8'd0) begin
							act_rep_d = act_rep_q - 8'd1;
							start     = 1'b1;
						end else begin
							still_valid = 1'b0;
						end
					end
					// Pick next queued packet or the idle packet
					if (!still_valid) begin
						if (fill_q == '0) begin
							act_payload_d = {24'd0, idle_second_q, idle_first_q};
							act_len_d     = MIN_LEN;
							act_rep_d     = 8'd0;
							act_idle_d    = 1'b1;
						end else begin
							act_payload_d = rd_q.payload;
							act_len_d     = rd_q.length;
							act_rep_d     = rd_q.repeats;
							act_idle_d    = 1'b0;
							head_d        = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
							                : head_q + PTR_W'(1);
							fill_d        = fill_q - FILL_W'(1);
						end
						act_valid_d = 1'b1;
						start       = 1'b1;
					end
					// Serial state, rewound at frame start
					e_idx   = start ? 7'd0 : act_idx_q;
					e_work  = start ? act_payload_d : work_q;
					e_octet = start ? 8'd0 : octet_q;
					e_csum  = start ? 8'd0 : csum_q;
					e_pos   = start ? 4'd0 : pos_q;
					e_byte  = start ? 3'd0 : byte_q;
					work_d  = e_work;
					octet_d = e_octet;
					csum_d  = e_csum;
					pos_d   = e_pos;
					byte_d  = e_byte;
					// Emit one bit
					if (e_idx < PREAMBLE_ONES) begin
						bit_v = 1'b1;
					end else if (e_pos == 4'd0) begin
						// start bit; load next octet or the checksum
						bit_v = 1'b0;
						if (e_byte < act_len_d) begin
							octet_d = e_work[7:0];
							work_d  = {8'd0, e_work[39:8]};
							csum_d  = e_csum ^ e_work[7:0];
						end else begin
							octet_d = e_csum;
						end
						byte_d = e_byte + 3'd1;
						pos_d  = 4'd1;
					end else begin
						bit_v   = e_octet[7];
						octet_d = {e_octet[6:0], 1'b0};
						pos_d   = (e_pos == LAST_POS) ? 4'd0 : e_pos + 4'd1;
					end
					act_idx_d  = e_idx + 7'd1;
					out_user_d = act_idle_d;
				end
				CMD_STOP: begin
					act_valid_d = 1'b0;
					act_idle_d  = 1'b0;
					act_idx_d   = 7'd0;
					act_rep_d   = 8'd0;
					head_d      = '0;
					tail_d      = '0;
					fill_d      = '0;
				end
				default: ;
			endcase
		end

		out_data_d = {1'b0, 5'(fill_d), acc_v, bit_v};
	end

	// Queue pointers and current packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			fill_q        <= '0;
			act_payload_q <= '0;
			act_len_q     <= '0;
			act_idx_q     <= '0;
			act_rep_q     <= '0;
			act_valid_q   <= 1'b0;
			act_idle_q    <= 1'b0;
		end else begin
			head_q        <= head_d;
			tail_q        <= tail_d;
			fill_q        <= fill_d;
			act_payload_q <= act_payload_d;
			act_len_q     <= act_len_d;
			act_idx_q     <= act_idx_d;
			act_rep_q     <= act_rep_d;
			act_valid_q   <= act_valid_d;
			act_idle_q    <= act_idle_d;
		end
	end

	// Serial shift registers
	always_ff @(posedge clk) begin
		work_q  <= work_d;
		octet_q <= octet_d;
		csum_q  <= csum_d;
		pos_q   <= pos_d;
		byte_q  <= byte_d;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (work_go) begin
			out_data_q <= out_data_d;
			out_user_q <= out_user_d;
		end
	end

	// Checks
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("queue fill above depth");

	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(tail_q - head_q) == fill_q[PTR_W-1:0])
		else $error("queue pointers disagree with fill");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid_q |-> act_idx_q <= frame_bits(act_len_q))
		else $error("bit index past frame end");

	a_idle_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(act_valid_q && act_idle_q) |-> (act_len_q == MIN_LEN && act_rep_q == 8'd0))
		else $error("idle packet with repeats or wrong length");

endmodule

[test/dcc_packet_serializer_tb.sv]
// ----------------------------------------------------------------------------
// dcc_packet_serializer_tb
// Self-checking bench for the DCC packet serializer. A directed run covers
// the length, queue-full, drain, stop and unknown-command cases. Four random
// phases follow, each with its own idle packet octets and its own
// back-pressure pattern. A transaction-level model of the queue and the framer
// predicts each result, and the bench checks every result in order.
// ----------------------------------------------------------------------------
module dcc_packet_serializer_tb;
	import dccps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Command code with no action in the block
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int RANDOM_PER_PHASE = 360;
	localparam int SETTLE_CYCLES    = 8;

	typedef struct {
		logic [1:0]  cmd;
		logic [55:0] data;
	} stim_item_t;

	typedef struct {
		logic       bit_out;
		logic       load_accepted;
		logic [4:0] pending_count;
		logic       sending_idle;
	} line_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	dcc_packet_serializer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	stim_item_t   pending_items[$];
	line_result_t expected_results[$];
	stim_item_t   drv_item;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           error_count;

	// Coverage tallies for the summary
	int n_loads, n_refused, n_bits, n_idle_bits, n_stops, n_other;

	// Shadow state of the serializer
	logic [39:0] q_payload [QUEUE_DEPTH];
	int          q_len     [QUEUE_DEPTH];
	logic [7:0]  q_repeats [QUEUE_DEPTH];
	int          q_head, q_tail, q_fill;
	logic [39:0] cur_payload;
	int          cur_len;
	logic [6:0]  cur_idx;
	logic [7:0]  cur_repeats;
	logic        cur_valid;
	logic        cur_idle;
	logic [7:0]  idle_lo, idle_hi;

	// Advance the shadow state by one transaction and return its result
	function automatic line_result_t serialize_step(input logic [1:0] cmd,
			input logic [55:0] data);
		line_result_t r;
		load_req_t    req;
		int           j, pos, k, flen;
		logic [7:0]   octet, chk;
		r = '{default: '0};
		req = data[$bits(load_req_t)-1:0];
		case (cmd)
			CMD_LOAD: begin
				if (req.drain_first) begin
					q_head = 0;
					q_tail = 0;
					q_fill = 0;
				end
				if (req.payload_length >= MIN_LEN && req.payload_length <= MAX_LEN &&
						q_fill < QUEUE_DEPTH) begin
					q_payload[q_tail] = '0;
					for (int i = 0; i < int'(req.payload_length); i++)
						q_payload[q_tail][8*i +: 8] = req.payload[8*i +: 8];
					q_len[q_tail]     = int'(req.payload_length);
					q_repeats[q_tail] = req.repeat_count;
					q_tail = (q_tail + 1) % QUEUE_DEPTH;
					q_fill++;
					r.load_accepted = 1'b1;
				end
			end
			CMD_BIT: begin
				flen = int'(PREAMBLE_ONES) + 9 * (cur_len + 1);
				if (cur_valid && int'(cur_idx) >= flen) begin
					if (cur_repeats > 0) begin
						cur_repeats--;
						cur_idx = '0;
					end else begin
						cur_valid = 1'b0;
					end
				end
				if (!cur_valid) begin
					if (q_fill == 0) begin
						cur_payload = {24'd0, idle_hi, idle_lo};
						cur_len     = 2;
						cur_repeats = '0;
						cur_idle    = 1'b1;
					end else begin
						cur_payload = q_payload[q_head];
						cur_len     = q_len[q_head];
						cur_repeats = q_repeats[q_head];
						cur_idle    = 1'b0;
						q_head = (q_head + 1) % QUEUE_DEPTH;
						q_fill--;
					end
					cur_idx   = '0;
					cur_valid = 1'b1;
				end
				// Preamble ones, then start bit plus octet, MSB first
				if (cur_idx < PREAMBLE_ONES) begin
					r.bit_out = 1'b1;
				end else begin
					j   = int'(cur_idx) - int'(PREAMBLE_ONES);
					pos = j % 9;
					k   = j / 9;
					if (pos != 0) begin
						chk = '0;
						for (int i = 0; i < cur_len; i++)
							chk ^= cur_payload[8*i +: 8];
						octet = (k < cur_len) ? cur_payload[8*k +: 8] : chk;
						r.bit_out = octet[8 - pos];
					end
				end
				cur_idx = cur_idx + 7'd1;
				r.sending_idle = cur_idle;
			end
			CMD_STOP: begin
				cur_valid   = 1'b0;
				cur_idle    = 1'b0;
				cur_idx     = '0;
				cur_repeats = '0;
				q_head = 0;
				q_tail = 0;
				q_fill = 0;
			end
			default: begin
			end
		endcase
		r.pending_count = q_fill[4:0];
		return r;
	endfunction

	function automatic logic [55:0] load_data(input int len, input logic [7:0] rep,
			input logic drain, input logic [39:0] payload);
		load_req_t req;
		req.drain_first    = drain;
		req.repeat_count   = rep;
		req.payload_length = len[2:0];
		req.payload        = payload;
		return {4'b0, req};
	endfunction

	function automatic logic [55:0] junk_data();
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		return {4'b0, wide[51:0]};
	endfunction

	task automatic push_item(input logic [1:0] cmd, input logic [55:0] data);
		stim_item_t it;
		it.cmd  = cmd;
		it.data = data;
		pending_items.insert(pending_items.size(), it);
	endtask

	// Bursts of loads, runs of bit requests, and some stops and noise
	task automatic add_random_traffic(input int count);
		int          added, mode, burst, len, rep;
		logic [63:0] wide;
		added = 0;
		while (added < count) begin
			mode = $urandom_range(99);
			if (mode < 30) begin
				burst = $urandom_range(1, 4);
				for (int i = 0; i < burst; i++) begin
					wide = {$urandom(), $urandom()};
					if ($urandom_range(99) < 10)
						len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(6, 7);
					else
						len = $urandom_range(MIN_LEN, MAX_LEN);
					rep = ($urandom_range(99) < 4) ? $urandom_range(0, 255) : $urandom_range(0, 3);
					push_item(CMD_LOAD, load_data(len, rep[7:0], $urandom_range(99) < 12,
						wide[39:0]));
				end
				added += burst;
			end else if (mode < 92) begin
				burst = $urandom_range(10, 120);
				if (burst > count - added)
					burst = count - added;
				for (int i = 0; i < burst; i++)
					push_item(CMD_BIT, junk_data());
				added += burst;
			end else if (mode < 97) begin
				push_item(CMD_STOP, junk_data());
				added++;
			end else begin
				// ignored by the block, not counted
				push_item(CMD_UNKNOWN, junk_data());
			end
		end
	endtask

	// Sender holds off until every result is back and the block has settled
	task automatic wait_until_drained();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Driver: next item once the previous transaction is taken
	always @(posedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= drv_item.cmd;
				s_axis_tdata  <= drv_item.data;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Monitor: predict on each input transaction, check each result
	always @(posedge clk) begin
		line_result_t want, seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IDLE_FIRST)
					idle_lo = cfg_data;
				else
					idle_hi = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = serialize_step(s_axis_tuser, s_axis_tdata);
				expected_results.insert(expected_results.size(), want);
				case (s_axis_tuser)
					CMD_LOAD: begin
						n_loads++;
						if (!want.load_accepted)
							n_refused++;
					end
					CMD_BIT: begin
						n_bits++;
						if (want.sending_idle)
							n_idle_bits++;
					end
					CMD_STOP: n_stops++;
					default:  n_other++;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen.bit_out       = m_axis_tdata[0];
				seen.load_accepted = m_axis_tdata[1];
				seen.pending_count = m_axis_tdata[6:2];
				seen.sending_idle  = m_axis_tuser;
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (seen.bit_out !== want.bit_out) begin
						$error("bit_out expected %0d got %0d", want.bit_out, seen.bit_out);
						error_count++;
					end
					if (seen.load_accepted !== want.load_accepted) begin
						$error("load_accepted expected %0d got %0d",
							want.load_accepted, seen.load_accepted);
						error_count++;
					end
					if (seen.pending_count !== want.pending_count) begin
						$error("pending_count expected %0d got %0d",
							want.pending_count, seen.pending_count);
						error_count++;
					end
					if (seen.sending_idle !== want.sending_idle) begin
						$error("sending_idle expected %0d got %0d",
							want.sending_idle, seen.sending_idle);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		#4ms;
		$display("dcc_packet_serializer_tb: FAIL");
		$finish;
	end

	initial begin
		logic [63:0] wide;
		logic [7:0]  phase_lo [4];
		logic [7:0]  phase_hi [4];
		int          phase_send [4];
		int          phase_recv [4];

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count = 0;
		n_loads = 0; n_refused = 0; n_bits = 0; n_idle_bits = 0; n_stops = 0; n_other = 0;

		q_head = 0; q_tail = 0; q_fill = 0;
		cur_payload = '0; cur_len = 0; cur_idx = '0; cur_repeats = '0;
		cur_valid = 1'b0; cur_idle = 1'b0;
		idle_lo = IDLE_FIRST_RST;
		idle_hi = IDLE_SECOND_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle packet from reset values, unknown command, stop
		push_item(CMD_BIT, {4'b0, {52{1'b1}}});
		push_item(CMD_UNKNOWN, {4'b0, {52{1'b1}}});
		push_item(CMD_STOP, '0);
		// illegal lengths
		push_item(CMD_LOAD, load_data(0, 8'h00, 1'b0, 40'h0));
		push_item(CMD_LOAD, load_data(1, 8'hFF, 1'b1, '1));
		push_item(CMD_LOAD, load_data(6, 8'h01, 1'b0, 40'hA5A5A5A5A5));
		push_item(CMD_LOAD, load_data(7, 8'hFF, 1'b0, '1));
		// every legal length, field extremes
		push_item(CMD_LOAD, load_data(2, 8'h00, 1'b0, 40'h0));
		push_item(CMD_LOAD, load_data(3, 8'hFF, 1'b0, '1));
		push_item(CMD_LOAD, load_data(4, 8'h01, 1'b0, 40'h5A3C96C3A5));
		push_item(CMD_LOAD, load_data(5, 8'hFF, 1'b0, '1));
		// fill the queue, then one load past full
		for (int i = 0; i < QUEUE_DEPTH - 4; i++) begin
			wide = {$urandom(), $urandom()};
			push_item(CMD_LOAD, load_data(MIN_LEN + i % 4, i[7:0], 1'b0, wide[39:0]));
		end
		push_item(CMD_LOAD, load_data(5, 8'h02, 1'b0, 40'h1122334455));
		// drain still happens on an illegal length
		push_item(CMD_LOAD, load_data(0, 8'h00, 1'b1, 40'h0));
		push_item(CMD_STOP, '0);
		wait_until_drained();

		// Random phases: idle octets and back-pressure per phase
		phase_lo = '{8'h00, 8'hFF, 8'h00, 8'h00};
		phase_hi = '{8'hFF, 8'hFF, 8'h00, 8'h00};
		phase_lo[3] = $urandom_range(0, 255);
		phase_hi[3] = $urandom_range(0, 255);
		phase_send = '{0, 76, 0, 37};
		phase_recv = '{0, 0, 76, 37};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_IDLE_FIRST, phase_lo[ph]);
			write_reg(REG_IDLE_SECOND, phase_hi[ph]);
			send_idle_pct  = phase_send[ph];
			recv_stall_pct = phase_recv[ph];
			add_random_traffic(RANDOM_PER_PHASE);
			wait_until_drained();
		end

		$display("covered %0d loads (%0d refused), %0d line bits (%0d of idle packets),",
			n_loads, n_refused, n_bits, n_idle_bits);
		$display("%0d stops and %0d unknown commands over four back-pressure phases",
			n_stops, n_other);
		if (error_count == 0)
			$display("dcc_packet_serializer_tb: PASS");
		else
			$display("dcc_packet_serializer_tb: FAIL");
		$finish;
	end

endmodule
